// ===== sv/okvt_pkg.sv =====
// shared constants, command and state codes, cell control bundle for the key/value table
package okvt_pkg;

    // table size and stored widths
    localparam int ENTRIES    = 256;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;

    // port field widths
    localparam int CMD_W     = 3;
    localparam int PORT_KEY_W = 32;
    localparam int PORT_VAL_W = 32;
    localparam int POS_W     = 8;
    localparam int COUNT_W   = 9;

    // derived widths
    localparam int KEY_W = (KEY_BITS < PORT_KEY_W) ? KEY_BITS : PORT_KEY_W;
    localparam int VAL_W = (VALUE_BITS < PORT_VAL_W) ? VALUE_BITS : PORT_VAL_W;
    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (IDX_W > POS_W) ? IDX_W : POS_W;

    typedef enum logic [CMD_W-1:0] {
        OP_INSERT  = 3'd0,
        OP_UPDATE  = 3'd1,
        OP_UPSERT  = 3'd2,
        OP_ERASE   = 3'd3,
        OP_GET_KEY = 3'd4,
        OP_GET_POS = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COMPARE,
        ST_COMMIT
    } state_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        op_t              op;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
        logic [POS_W-1:0] pos;
        logic [CNT_W-1:0] count;
        logic [IDX_W-1:0] hit_pos;
        logic             compare;
        logic             wr_update;
        logic             wr_insert;
        logic             wr_erase;
    } cell_ctrl_t;

endpackage

// ===== sv/okvt_req_if.sv =====
// command channel: valid/ready with the command fields
interface okvt_req_if;
    logic                              valid;
    logic                              ready;
    logic [okvt_pkg::CMD_W-1:0]        cmd;
    logic [okvt_pkg::PORT_KEY_W-1:0]   key_in;
    logic [okvt_pkg::PORT_VAL_W-1:0]   new_value;
    logic [okvt_pkg::POS_W-1:0]        position;

    modport source (output valid, output cmd, output key_in, output new_value,
                    output position, input ready);
    modport sink   (input valid, input cmd, input key_in, input new_value,
                    input position, output ready);
endinterface

// ===== sv/okvt_rsp_if.sv =====
// result channel: valid/ready with the result fields
interface okvt_rsp_if;
    logic                              valid;
    logic                              ready;
    logic                              ok;
    logic [okvt_pkg::PORT_KEY_W-1:0]   key_out;
    logic [okvt_pkg::PORT_VAL_W-1:0]   value_out;
    logic [okvt_pkg::COUNT_W-1:0]      count;
    logic                              is_empty;

    modport source (output valid, output ok, output key_out, output value_out,
                    output count, output is_empty, input ready);
    modport sink   (input valid, input ok, input key_out, input value_out,
                    input count, input is_empty, output ready);
endinterface

// ===== sv/ordered_key_value_table_core.sv =====
// top level of the ordered key/value table: command control, row of slot cells, result register
//
// usage
//   req carries one command per beat: cmd, key_in, new_value, position.
//   rsp returns exactly one result beat per command: ok, key_out, value_out,
//   count (entries after the command) and is_empty.
//   a command beat is registered, every slot compares its key (or its
//   position for get by position) in the following cycle and registers its
//   match flag, and in the commit step the table is changed and the result
//   is loaded into the output register.
//   a new beat is taken only while idle or in the same cycle as the previous
//   command commits, so the compare always sees the table as left by the
//   command before; the registered match flags in the cells and the commit
//   step that follows lie between a beat and its result.
//   erase pulls every slot above the match down one place in the commit
//   cycle, so order is kept; the match position is broadcast to the whole
//   row.
//   when rsp stalls, the finished result waits in the output register; the
//   next command holds in its commit step until the output register is
//   free, and no new beat is accepted meanwhile.
//   reset clears the entry count and the control state; slot contents are
//   left as they are, and only slots below the count are ever read.
module ordered_key_value_table_core (
    input  logic       clk,
    input  logic       rst_n,
    okvt_req_if.sink   req,
    okvt_rsp_if.source rsp
);

    localparam int N = okvt_pkg::ENTRIES;

    // command register
    okvt_pkg::op_t                 op_reg;
    logic [okvt_pkg::KEY_W-1:0]    key_reg;
    logic [okvt_pkg::VAL_W-1:0]    value_reg;
    logic [okvt_pkg::POS_W-1:0]    pos_reg;

    // table occupancy
    logic [okvt_pkg::CNT_W-1:0]    count_reg;
    logic [okvt_pkg::CNT_W-1:0]    count_next;

    // control
    okvt_pkg::state_t              state_reg;
    okvt_pkg::state_t              state_next;
    logic                          accept;
    logic                          commit;
    logic                          compare;
    logic                          ready_c;

    // output register
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic                          ok_reg;
    logic                          ok_next;
    logic [okvt_pkg::PORT_KEY_W-1:0] key_out_reg;
    logic [okvt_pkg::PORT_KEY_W-1:0] key_out_next;
    logic [okvt_pkg::PORT_VAL_W-1:0] value_out_reg;
    logic [okvt_pkg::PORT_VAL_W-1:0] value_out_next;
    logic [okvt_pkg::COUNT_W-1:0]  count_out_reg;
    logic                          empty_reg;

    // cell row
    okvt_pkg::cell_ctrl_t          ctrl;
    logic [okvt_pkg::KEY_W-1:0]    cell_key [N];
    logic [okvt_pkg::VAL_W-1:0]    cell_value [N];
    logic [okvt_pkg::KEY_W-1:0]    nb_key [N];
    logic [okvt_pkg::VAL_W-1:0]    nb_value [N];
    logic                          cell_hit [N];

    // command outcome
    logic                          any_hit;
    logic [okvt_pkg::IDX_W-1:0]    hit_pos;
    logic                          full;
    logic                          ins_ok;
    logic                          upd_ok;
    logic                          ers_ok;
    logic [okvt_pkg::KEY_W-1:0]    sel_key;
    logic [okvt_pkg::VAL_W-1:0]    sel_value;

    // ---------------------------------------------------------------
    // state machine
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            okvt_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = okvt_pkg::ST_COMPARE;
                end
            end
            okvt_pkg::ST_COMPARE:
            begin
                state_next = okvt_pkg::ST_COMMIT;
            end
            okvt_pkg::ST_COMMIT:
            begin
                if (commit)
                begin
                    state_next = req.valid ? okvt_pkg::ST_COMPARE : okvt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = okvt_pkg::ST_IDLE;
            end
        endcase
    end

    // commit waits only for room in the output register
    always_comb
    begin
        ready_c = 1'b0;
        compare = 1'b0;
        commit  = 1'b0;
        unique case (state_reg)
            okvt_pkg::ST_IDLE:
            begin
                ready_c = 1'b1;
            end
            okvt_pkg::ST_COMPARE:
            begin
                compare = 1'b1;
            end
            okvt_pkg::ST_COMMIT:
            begin
                commit  = !out_valid_reg || rsp.ready;
                ready_c = commit;
            end
            default:
            begin
                ready_c = 1'b0;
            end
        endcase
    end

    assign req.ready = ready_c;
    assign accept    = req.valid && ready_c;

    // ---------------------------------------------------------------
    // outcome of the registered compare
    // ---------------------------------------------------------------
    assign full    = count_reg == okvt_pkg::CNT_W'(N);
    assign ins_ok  = ((op_reg == okvt_pkg::OP_INSERT) || (op_reg == okvt_pkg::OP_UPSERT))
                     && !any_hit && !full;
    assign upd_ok  = ((op_reg == okvt_pkg::OP_UPDATE) || (op_reg == okvt_pkg::OP_UPSERT))
                     && any_hit;
    assign ers_ok  = (op_reg == okvt_pkg::OP_ERASE) && any_hit;

    // at most one slot matches, so an and-or picks its contents and its position
    always_comb
    begin
        any_hit   = 1'b0;
        hit_pos   = '0;
        sel_key   = '0;
        sel_value = '0;
        for (int i = 0; i < N; i++)
        begin
            any_hit   = any_hit | cell_hit[i];
            hit_pos   = hit_pos |
                        (okvt_pkg::IDX_W'(i) & {okvt_pkg::IDX_W{cell_hit[i]}});
            sel_key   = sel_key   | (cell_key[i]   & {okvt_pkg::KEY_W{cell_hit[i]}});
            sel_value = sel_value | (cell_value[i] & {okvt_pkg::VAL_W{cell_hit[i]}});
        end
    end

    always_comb
    begin
        ok_next        = 1'b0;
        key_out_next   = '0;
        value_out_next = '0;
        unique case (op_reg)
            okvt_pkg::OP_INSERT:
            begin
                ok_next = ins_ok;
            end
            okvt_pkg::OP_UPDATE:
            begin
                ok_next = any_hit;
            end
            okvt_pkg::OP_UPSERT:
            begin
                ok_next = any_hit || ins_ok;
            end
            okvt_pkg::OP_ERASE:
            begin
                ok_next = any_hit;
            end
            okvt_pkg::OP_GET_KEY:
            begin
                ok_next = any_hit;
                if (any_hit)
                begin
                    value_out_next = okvt_pkg::PORT_VAL_W'(sel_value);
                end
            end
            okvt_pkg::OP_GET_POS:
            begin
                ok_next = any_hit;
                if (any_hit)
                begin
                    key_out_next   = okvt_pkg::PORT_KEY_W'(sel_key);
                    value_out_next = okvt_pkg::PORT_VAL_W'(sel_value);
                end
            end
            default:
            begin
                ok_next = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (commit && ins_ok)
        begin
            count_next = count_reg + okvt_pkg::CNT_W'(1);
        end
        else if (commit && ers_ok)
        begin
            count_next = count_reg - okvt_pkg::CNT_W'(1);
        end
        else
        begin
            count_next = count_reg;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // ---------------------------------------------------------------
    // cell row
    // ---------------------------------------------------------------
    always_comb
    begin
        ctrl.op        = op_reg;
        ctrl.key       = key_reg;
        ctrl.value     = value_reg;
        ctrl.pos       = pos_reg;
        ctrl.count     = count_reg;
        ctrl.hit_pos   = hit_pos;
        ctrl.compare   = compare;
        ctrl.wr_update = commit && upd_ok;
        ctrl.wr_insert = commit && ins_ok;
        ctrl.wr_erase  = commit && ers_ok;
    end

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        // top slot has no upper neighbour; what it takes on erase lies past the count
        if (i == N - 1)
        begin : g_last
            assign nb_key[i]   = cell_key[i];
            assign nb_value[i] = cell_value[i];
        end
        else
        begin : g_mid
            assign nb_key[i]   = cell_key[i+1];
            assign nb_value[i] = cell_value[i+1];
        end

        okvt_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .idx        (okvt_pkg::IDX_W'(i)),
            .ctrl       (ctrl),
            .next_key   (nb_key[i]),
            .next_value (nb_value[i]),
            .key        (cell_key[i]),
            .value      (cell_value[i]),
            .hit        (cell_hit[i])
        );
    end

    // ---------------------------------------------------------------
    // registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= okvt_pkg::ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // command payload, masked to the stored widths
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= okvt_pkg::op_t'(req.cmd);
            key_reg   <= req.key_in[okvt_pkg::KEY_W-1:0];
            value_reg <= req.new_value[okvt_pkg::VAL_W-1:0];
            pos_reg   <= req.position;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            ok_reg        <= ok_next;
            key_out_reg   <= key_out_next;
            value_out_reg <= value_out_next;
            count_out_reg <= okvt_pkg::COUNT_W'(count_next);
            empty_reg     <= count_next == '0;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.ok        = ok_reg;
    assign rsp.key_out   = key_out_reg;
    assign rsp.value_out = value_out_reg;
    assign rsp.count     = count_out_reg;
    assign rsp.is_empty  = empty_reg;

endmodule

// ===== sv/okvt_cell.sv =====
// one table slot: stored key and value, match flag, erase shift from the upper neighbour
module okvt_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [okvt_pkg::IDX_W-1:0]    idx,
    input  okvt_pkg::cell_ctrl_t          ctrl,
    input  logic [okvt_pkg::KEY_W-1:0]    next_key,
    input  logic [okvt_pkg::VAL_W-1:0]    next_value,
    output logic [okvt_pkg::KEY_W-1:0]    key,
    output logic [okvt_pkg::VAL_W-1:0]    value,
    output logic                          hit
);

    logic [okvt_pkg::KEY_W-1:0] key_reg;
    logic [okvt_pkg::KEY_W-1:0] key_next;
    logic [okvt_pkg::VAL_W-1:0] value_reg;
    logic [okvt_pkg::VAL_W-1:0] value_next;
    logic                       hit_reg;
    logic                       hit_next;
    logic                       in_range;
    logic                       sel;

    always_comb
    begin
        in_range = okvt_pkg::CNT_W'(idx) < ctrl.count;
        if (ctrl.op == okvt_pkg::OP_GET_POS)
        begin
            sel = in_range &&
                  (okvt_pkg::CMP_W'(idx) == okvt_pkg::CMP_W'(ctrl.pos));
        end
        else
        begin
            sel = in_range && (key_reg == ctrl.key);
        end
        hit_next = ctrl.compare ? sel : hit_reg;
    end

    // a match at or below this slot means an erase pulls the upper entry down
    always_comb
    begin
        key_next   = key_reg;
        value_next = value_reg;
        priority if (ctrl.wr_erase && (idx >= ctrl.hit_pos))
        begin
            key_next   = next_key;
            value_next = next_value;
        end
        else if (ctrl.wr_insert && (okvt_pkg::CNT_W'(idx) == ctrl.count))
        begin
            key_next   = ctrl.key;
            value_next = ctrl.value;
        end
        else if (ctrl.wr_update && hit_reg)
        begin
            value_next = ctrl.value;
        end
        else
        begin
            key_next   = key_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else
        begin
            hit_reg <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        value_reg <= value_next;
    end

    assign key   = key_reg;
    assign value = value_reg;
    assign hit   = hit_reg;

endmodule

// ===== sim/tb_ordered_key_value_table_core.sv =====
`timescale 1ns / 100ps
// testbench for the ordered key/value table: directed command table, then random traffic
module tb_ordered_key_value_table_core;
    import okvt_pkg::*;

    localparam int HALF_PERIOD     = 6;
    localparam int RESET_CYCLES    = 9;
    localparam int ITEM_TARGET     = 1250;
    localparam int IDLE_PCT        = 32;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int STEADY_BEATS    = 120;
    localparam int DRAIN_CYCLES    = 10;
    // about 1300 beats, stretched by both sides idling and one long hold-off, stay far below this
    localparam int CYCLE_LIMIT     = 200000;

    // command codes the block leaves unused
    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

    // one result beat as the block reports it
    typedef struct packed {
        logic                  ok;
        logic [PORT_KEY_W-1:0] key_out;
        logic [PORT_VAL_W-1:0] value_out;
        logic [COUNT_W-1:0]    count;
        logic                  is_empty;
    } table_result_t;

    // one row of the directed table; typed rows carry their own answer
    typedef struct packed {
        logic [CMD_W-1:0]      op;
        logic [PORT_KEY_W-1:0] key;
        logic [PORT_VAL_W-1:0] value;
        logic [POS_W-1:0]      pos;
        logic                  typed;
        table_result_t         want;
    } directed_row_t;

    localparam table_result_t NO_TYPED = '0;

    // op, key, value, position, typed, typed answer (ok, key, value, count, empty)
    localparam directed_row_t DIRECTED_ROWS [24] = '{
        // empty table straight after reset
        '{OP_GET_POS, 32'h0, 32'h0, 8'd0, 1'b1, '{1'b0, 32'h0, 32'h0, 9'd0, 1'b1}},
        '{OP_GET_KEY, 32'h0, 32'h0, 8'd0, 1'b1, '{1'b0, 32'h0, 32'h0, 9'd0, 1'b1}},
        '{OP_UPDATE, 32'hFFFF_FFFF, 32'h1, 8'd0, 1'b1, '{1'b0, 32'h0, 32'h0, 9'd0, 1'b1}},
        '{OP_ERASE, 32'h0, 32'h0, 8'd0, 1'b1, '{1'b0, 32'h0, 32'h0, 9'd0, 1'b1}},
        // extreme keys and values
        '{OP_INSERT, 32'h0, 32'hFFFF_FFFF, 8'd0, 1'b1, '{1'b1, 32'h0, 32'h0, 9'd1, 1'b0}},
        '{OP_INSERT, 32'hFFFF_FFFF, 32'h0, 8'd0, 1'b1, '{1'b1, 32'h0, 32'h0, 9'd2, 1'b0}},
        // duplicate key on insert keeps the stored value
        '{OP_INSERT, 32'h0, 32'h1234_5678, 8'd0, 1'b1, '{1'b0, 32'h0, 32'h0, 9'd2, 1'b0}},
        '{OP_GET_KEY, 32'h0, 32'h0, 8'd0, 1'b1,
          '{1'b1, 32'h0, 32'hFFFF_FFFF, 9'd2, 1'b0}},
        '{OP_GET_POS, 32'h0, 32'h0, 8'd1, 1'b1,
          '{1'b1, 32'hFFFF_FFFF, 32'h0, 9'd2, 1'b0}},
        // positions at and far beyond the count
        '{OP_GET_POS, 32'h0, 32'h0, 8'd2, 1'b1, '{1'b0, 32'h0, 32'h0, 9'd2, 1'b0}},
        '{OP_GET_POS, 32'h0, 32'h0, 8'd255, 1'b1, '{1'b0, 32'h0, 32'h0, 9'd2, 1'b0}},
        '{OP_UPDATE, 32'hFFFF_FFFF, 32'h5A5A_5A5A, 8'd0, 1'b1,
          '{1'b1, 32'h0, 32'h0, 9'd2, 1'b0}},
        // insert-or-update, once on each branch
        '{OP_UPSERT, 32'h0, 32'h0, 8'd0, 1'b1, '{1'b1, 32'h0, 32'h0, 9'd2, 1'b0}},
        '{OP_UPSERT, 32'h8000_0000, 32'hA5A5_A5A5, 8'd0, 1'b1,
          '{1'b1, 32'h0, 32'h0, 9'd3, 1'b0}},
        // unused codes answer with the count only
        '{CMD_SPARE_LO, 32'h0, 32'h0, 8'd0, 1'b1, '{1'b0, 32'h0, 32'h0, 9'd3, 1'b0}},
        '{CMD_SPARE_HI, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd255, 1'b1,
          '{1'b0, 32'h0, 32'h0, 9'd3, 1'b0}},
        // erase the oldest entry, later ones move down
        '{OP_ERASE, 32'h0, 32'h0, 8'd0, 1'b1, '{1'b1, 32'h0, 32'h0, 9'd2, 1'b0}},
        '{OP_GET_POS, 32'h0, 32'h0, 8'd0, 1'b0, NO_TYPED},
        '{OP_GET_POS, 32'h0, 32'h0, 8'd1, 1'b0, NO_TYPED},
        '{OP_GET_KEY, 32'h8000_0000, 32'h0, 8'd0, 1'b0, NO_TYPED},
        // erase the newest, then the last one left
        '{OP_ERASE, 32'h8000_0000, 32'h0, 8'd0, 1'b1, '{1'b1, 32'h0, 32'h0, 9'd1, 1'b0}},
        '{OP_UPDATE, 32'h0, 32'h1, 8'd0, 1'b1, '{1'b0, 32'h0, 32'h0, 9'd1, 1'b0}},
        '{OP_ERASE, 32'hFFFF_FFFF, 32'h0, 8'd0, 1'b1, '{1'b1, 32'h0, 32'h0, 9'd0, 1'b1}},
        '{OP_GET_POS, 32'h0, 32'h0, 8'd0, 1'b1, '{1'b0, 32'h0, 32'h0, 9'd0, 1'b1}}
    };

    logic clk = 1'b0;
    logic rst_n;

    okvt_req_if req_bus ();
    okvt_rsp_if rsp_bus ();

    ordered_key_value_table_core u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    // shadow copy of the table, in insertion order
    logic [KEY_W-1:0] shadow_keys   [ENTRIES];
    logic [VAL_W-1:0] shadow_values [ENTRIES];
    int               shadow_count;

    // answers still owed by the block, oldest first
    table_result_t pending_results [$];

    int mismatch_count   = 0;
    int items_sent       = 0;
    int cycle_count      = 0;
    bit steady_run       = 1'b0;
    bit hold_off_request = 1'b0;

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // shadow table behaviour
    // ------------------------------------------------------------------

    // position of the key, or -1 when absent
    function automatic int find_entry(input logic [KEY_W-1:0] k);
        for (int i = 0; i < shadow_count; i++)
            if (shadow_keys[i] == k)
                return i;
        return -1;
    endfunction

    // add at the tail unless the table is full
    function automatic bit append_entry(input logic [KEY_W-1:0] k, input logic [VAL_W-1:0] v);
        if (shadow_count >= ENTRIES)
            return 1'b0;
        shadow_keys[shadow_count]   = k;
        shadow_values[shadow_count] = v;
        shadow_count++;
        return 1'b1;
    endfunction

    // apply one command to the shadow table and return the answer it owes
    function automatic table_result_t apply_command(input logic [CMD_W-1:0] op,
                                                    input logic [PORT_KEY_W-1:0] key,
                                                    input logic [PORT_VAL_W-1:0] value,
                                                    input logic [POS_W-1:0] pos);
        table_result_t    res;
        logic [KEY_W-1:0] k;
        logic [VAL_W-1:0] v;
        int               at;
        res = '0;
        k   = key[KEY_W-1:0];
        v   = value[VAL_W-1:0];
        at  = find_entry(k);
        case (op)
            OP_INSERT:
                if (at < 0)
                    res.ok = append_entry(k, v);
            OP_UPDATE:
                if (at >= 0)
                begin
                    shadow_values[at] = v;
                    res.ok = 1'b1;
                end
            OP_UPSERT:
                // a present key is updated even when the table is full
                if (at >= 0)
                begin
                    shadow_values[at] = v;
                    res.ok = 1'b1;
                end
                else
                    res.ok = append_entry(k, v);
            OP_ERASE:
                if (at >= 0)
                begin
                    // close the gap so insertion order is kept
                    for (int j = at; j < shadow_count - 1; j++)
                    begin
                        shadow_keys[j]   = shadow_keys[j + 1];
                        shadow_values[j] = shadow_values[j + 1];
                    end
                    shadow_count--;
                    res.ok = 1'b1;
                end
            OP_GET_KEY:
                if (at >= 0)
                begin
                    res.ok        = 1'b1;
                    res.value_out = shadow_values[at];
                end
            OP_GET_POS:
                if (int'(pos) < shadow_count)
                begin
                    res.ok        = 1'b1;
                    res.key_out   = shadow_keys[pos];
                    res.value_out = shadow_values[pos];
                end
            default:
                ;
        endcase
        res.count    = shadow_count[COUNT_W-1:0];
        res.is_empty = (shadow_count == 0);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // random field choice
    // ------------------------------------------------------------------

    // mostly live keys so that lookups hit, some keys near both extremes, rest anywhere
    function automatic logic [PORT_KEY_W-1:0] pick_key();
        int roll;
        roll = $urandom_range(99);
        if (roll < 55 && shadow_count > 0)
            return shadow_keys[$urandom_range(shadow_count - 1)];
        if (roll < 75)
            return ($urandom_range(1) ? 32'hFFFF_FFF0 : 32'h0) | $urandom_range(15);
        return $urandom();
    endfunction

    // mostly within the table, the count itself included, now and then anywhere
    function automatic logic [POS_W-1:0] pick_position();
        if (shadow_count > 0 && $urandom_range(3) != 0)
            return $urandom_range(shadow_count > 255 ? 255 : shadow_count);
        return $urandom_range(255);
    endfunction

    function automatic logic [CMD_W-1:0] pick_command();
        int roll;
        roll = $urandom_range(99);
        if (roll < 24)
            return OP_INSERT;
        if (roll < 36)
            return OP_UPDATE;
        if (roll < 50)
            return OP_UPSERT;
        if (roll < 64)
            return OP_ERASE;
        if (roll < 80)
            return OP_GET_KEY;
        if (roll < 96)
            return OP_GET_POS;
        if (roll < 98)
            return CMD_SPARE_LO;
        return CMD_SPARE_HI;
    endfunction

    // ------------------------------------------------------------------
    // command side
    // ------------------------------------------------------------------

    // offer one command beat and wait until it is taken; the answer is worked out on
    // acceptance, so the shadow table always runs in step with the block
    task automatic send_command(input logic [CMD_W-1:0] op, input logic [PORT_KEY_W-1:0] key,
                                input logic [PORT_VAL_W-1:0] value,
                                input logic [POS_W-1:0] pos,
                                input logic typed, input table_result_t want);
        table_result_t predicted;
        // random gaps ahead of the beat, none during the steady stretch
        while (!steady_run && $urandom_range(99) < IDLE_PCT)
        begin
            req_bus.valid <= 1'b0;
            @(posedge clk);
        end
        req_bus.valid     <= 1'b1;
        req_bus.cmd       <= op;
        req_bus.key_in    <= key;
        req_bus.new_value <= value;
        req_bus.position  <= pos;
        @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);
        predicted = apply_command(op, key, value, pos);
        pending_results.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    task automatic send_random();
        send_command(pick_command(), pick_key(), $urandom(), pick_position(), 1'b0, NO_TYPED);
    endtask

    initial
    begin : stimulus
        int               fill_start;
        logic [CMD_W-1:0] op;
        rst_n             <= 1'b0;
        req_bus.valid     <= 1'b0;
        req_bus.cmd       <= OP_INSERT;
        req_bus.key_in    <= '0;
        req_bus.new_value <= '0;
        req_bus.position  <= '0;
        shadow_count = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // directed table
        for (int r = 0; r < $size(DIRECTED_ROWS); r++)
            send_command(DIRECTED_ROWS[r].op, DIRECTED_ROWS[r].key, DIRECTED_ROWS[r].value,
                         DIRECTED_ROWS[r].pos, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);

        // mixed traffic on a small table; the long result hold-off falls in here
        for (int n = 0; n < 380; n++)
        begin
            if (n == 100)
                hold_off_request = 1'b1;
            send_random();
        end

        // fill up to the last slot, the first stretch with neither side idling
        fill_start = items_sent;
        while (shadow_count < ENTRIES)
        begin
            steady_run = (items_sent - fill_start) < STEADY_BEATS;
            if ($urandom_range(99) < 85)
                send_command(OP_INSERT, $urandom(), $urandom(), pick_position(),
                             1'b0, NO_TYPED);
            else
                send_random();
        end
        steady_run = 1'b0;

        // full table: inserts fail, upserts only update, no erases
        repeat (40)
        begin
            op = pick_command();
            if (op == OP_ERASE)
                op = OP_UPSERT;
            send_command(op, pick_key(), $urandom(), pick_position(), 1'b0, NO_TYPED);
        end

        // drain by erasing live keys anywhere in the order
        while (shadow_count > 8)
        begin
            if ($urandom_range(99) < 70)
                send_command(OP_ERASE, shadow_keys[$urandom_range(shadow_count - 1)],
                             $urandom(), pick_position(), 1'b0, NO_TYPED);
            else
                send_random();
        end

        // mixed tail up to the item target
        for (int n = 0; n < 40 || items_sent < ITEM_TARGET; n++)
            send_random();

        req_bus.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        // catch any stray result beat after the last expected one
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------

    // ready idles at random, stays high for the steady stretch, and once holds off
    // for a long run of cycles so that the block backs up into its command port
    initial
    begin : result_ready
        int hold_left;
        hold_left = 0;
        rsp_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_request)
            begin
                hold_off_request = 1'b0;
                hold_left = HOLD_OFF_CYCLES;
                rsp_bus.ready <= 1'b0;
            end
            else if (hold_left > 0)
                hold_left--;
            else
                rsp_bus.ready <= steady_run || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    task automatic compare_field(input string name, input logic [PORT_VAL_W-1:0] want,
                                 input logic [PORT_VAL_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // every accepted result beat against the oldest answer owed
    always @(posedge clk)
    begin : result_check
        table_result_t expected;
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result beat with no command outstanding", $time);
                mismatch_count++;
            end
            else
            begin
                expected = pending_results.pop_front();
                compare_field("ok", expected.ok, rsp_bus.ok);
                compare_field("key_out", expected.key_out, rsp_bus.key_out);
                compare_field("value_out", expected.value_out, rsp_bus.value_out);
                compare_field("count", expected.count, rsp_bus.count);
                compare_field("is_empty", expected.is_empty, rsp_bus.is_empty);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("simulation failed");
            $finish;
        end
    end

endmodule
